// File: rtl/pspf_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_pkg
// Shared types and constants for the packet size pivot fingerprint block.
// ----------------------------------------------------------------------------
package pspf_pkg;
  localparam int WINDOW_FRAMES = 20;
  localparam int MAX_PIVOTS    = 16;
  localparam int SIZE_BITS     = 16;
  localparam int HOLD          = 5;
  localparam int SUM_BITS      = 22;
  localparam int CNT_BITS      = 6;
  localparam int FC_BITS       = 7;
  localparam int PC_BITS       = 5;
  localparam int PI_BITS       = 4;
  localparam int Q_BITS        = 17;
  localparam logic [SUM_BITS-1:0] SUM_MAX = 22'h3FFFFF;
  localparam logic [CNT_BITS-1:0] CNT_MAX = 6'h3F;
  localparam logic [1:0] KIND_SHORT  = 2'd0;
  localparam logic [1:0] KIND_MIDDLE = 2'd1;
  localparam logic [1:0] KIND_LONG   = 2'd2;

  // Request from the input queue to the front: one frame.
  typedef struct packed {
    logic [SIZE_BITS-1:0] size;
    logic                 start;
  } frame_req_t;

  typedef struct packed {
    logic                 pivot_found;
    logic [15:0]          mode_size;
    logic [15:0]          largest_size;
    logic [SUM_BITS-1:0]  total_size;
    logic [Q_BITS-1:0]    pivot_to_largest;
    logic [Q_BITS-1:0]    pivot_to_total;
    logic [CNT_BITS-1:0]  count_short;
    logic [CNT_BITS-1:0]  count_middle;
    logic [CNT_BITS-1:0]  count_long;
  } result_t;
endpackage

// File: rtl/pspf_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_fifo
// Two-entry request queue between the input and the front.
// ----------------------------------------------------------------------------
module pspf_fifo import pspf_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       wr_valid,
  output logic       wr_ready,
  input  frame_req_t wr_data,
  output logic       rd_valid,
  input  logic       rd_ready,
  output frame_req_t rd_data
);
  frame_req_t mem_r [2];
  logic       wp_r, rp_r;
  logic [1:0] cnt_r;
  logic       wr, rd;

  assign wr_ready = (cnt_r != 2'd2);
  assign rd_valid = (cnt_r != 2'd0);
  assign rd_data  = mem_r[rp_r];
  assign wr = wr_valid && wr_ready;
  assign rd = rd_valid && rd_ready;

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wr_data;
    if (!rst_n) begin
      wp_r <= 1'b0; rp_r <= 1'b0; cnt_r <= 2'd0;
    end else begin
      if (wr) wp_r <= ~wp_r;
      if (rd) rp_r <= ~rp_r;
      cnt_r <= cnt_r + {1'b0, wr} - {1'b0, rd};
    end
  end
endmodule

// File: rtl/pspf_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_front
// Window update: running maximum, sum, recent sizes and pattern matching.
// Signals a finished window to the back end.
// ----------------------------------------------------------------------------
module pspf_front import pspf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  req_valid,
  output logic                  req_ready,
  input  frame_req_t            req,
  output logic                  done_valid,
  input  logic                  done_ready,
  output logic [SIZE_BITS-1:0]  max_o,
  output logic [SUM_BITS-1:0]   sum_o,
  output logic [CNT_BITS-1:0]   cnt_o [3],
  output logic [PC_BITS-1:0]    pcount_o,
  output logic [SIZE_BITS-1:0]  plist_o [MAX_PIVOTS]
);
  logic [SIZE_BITS-1:0] r_r [HOLD];
  logic [2:0]           rc_r;
  logic [SIZE_BITS-1:0] max_r;
  logic                 seen_r;
  logic [FC_BITS-1:0]   fc_r;
  logic [SUM_BITS-1:0]  sum_r;
  logic [SIZE_BITS-1:0] pl_r [MAX_PIVOTS];
  logic [PC_BITS-1:0]   pc_r;
  logic [CNT_BITS-1:0]  pat_r [3];
  logic                 done_r;

  assign req_ready  = !done_r;
  assign done_valid = done_r;
  assign max_o = max_r;
  assign sum_o = sum_r;
  assign cnt_o = pat_r;
  assign pcount_o = pc_r;
  assign plist_o = pl_r;

  always_ff @(posedge clk) begin
    logic [SIZE_BITS-1:0] r [HOLD];
    logic [2:0]           rc;
    logic [SIZE_BITS-1:0] mx;
    logic                 sn;
    logic [FC_BITS-1:0]   fc;
    logic [SUM_BITS-1:0]  sm;
    logic [PC_BITS-1:0]   pc;
    logic [CNT_BITS-1:0]  pat [3];
    logic [SUM_BITS:0]    s2;
    logic                 np;
    logic [1:0]           kind;
    logic [SIZE_BITS-1:0] pv;
    logic                 a0, a1, a2, a3;
    r = r_r; rc = rc_r; mx = max_r; sn = seen_r; fc = fc_r; sm = sum_r;
    pc = pc_r; pat = pat_r; np = 1'b0; kind = KIND_SHORT; pv = '0;
    if (!rst_n) begin
      rc_r <= '0; max_r <= '0; seen_r <= 1'b0; fc_r <= '0; sum_r <= '0;
      pc_r <= '0; pat_r <= '{default: '0}; done_r <= 1'b0;
    end else begin
      if (done_r && done_ready) done_r <= 1'b0;
      if (req_valid && req_ready) begin
        if (req.start) begin
          rc = '0; mx = '0; sn = 1'b0; fc = '0; sm = '0; pc = '0;
          pat = '{default: '0};
        end
        if (fc < FC_BITS'(WINDOW_FRAMES)) begin
          s2 = {1'b0, sm} + (SUM_BITS+1)'(req.size);
          sm = s2[SUM_BITS] ? SUM_MAX : s2[SUM_BITS-1:0];
          a0 = sn && r[0] == mx; a1 = sn && r[1] == mx;
          a2 = sn && r[2] == mx; a3 = sn && r[3] == mx;
          case (rc)
            3'd5: begin
              if (r[0] == r[4]) begin np = 1'b1; kind = KIND_LONG; pv = r[3]; end
              r[0] = r[4]; rc = 3'd1;
            end
            3'd4: begin
              if (a0 && a3) begin
                np = 1'b1; kind = KIND_MIDDLE; pv = r[2]; r[0] = r[3]; rc = 3'd1;
              end
            end
            3'd3: begin
              if (a0 && a2) begin
                if (r[1] != r[0]) begin np = 1'b1; kind = KIND_SHORT; pv = r[1]; end
                r[0] = r[2]; rc = 3'd1;
              end else if (a1 || a0) begin
                if (r[0] == r[1]) begin r[0] = r[1]; r[1] = r[2]; rc = 3'd2; end
              end else begin
                r[0] = r[2]; rc = 3'd1;
              end
            end
            default: ;
          endcase
          if (np) begin
            if (pc < PC_BITS'(MAX_PIVOTS)) begin
              pl_r[pc[PI_BITS-1:0]] <= pv; pc = pc + 1'b1;
            end
            if (pat[kind] != CNT_MAX) pat[kind] = pat[kind] + 1'b1;
          end
          r[rc] = req.size; rc = rc + 1'b1;
          if (!sn || req.size > mx) begin mx = req.size; sn = 1'b1; end
          fc = fc + 1'b1;
          if (fc == FC_BITS'(WINDOW_FRAMES)) done_r <= 1'b1;
        end
        r_r <= r; rc_r <= rc; max_r <= mx; seen_r <= sn; fc_r <= fc;
        sum_r <= sm; pc_r <= pc; pat_r <= pat;
      end
    end
  end
endmodule

// File: rtl/pspf_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// pspf_back
// Pivot mode scan and two restoring divisions, then holds the result.
// ----------------------------------------------------------------------------
module pspf_back import pspf_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  go_valid,
  output logic                  go_ready,
  input  logic [SIZE_BITS-1:0]  max_i,
  input  logic [SUM_BITS-1:0]   sum_i,
  input  logic [CNT_BITS-1:0]   cnt_i [3],
  input  logic [PC_BITS-1:0]    pcount_i,
  input  logic [SIZE_BITS-1:0]  plist_i [MAX_PIVOTS],
  output logic                  res_valid,
  input  logic                  res_ready,
  output result_t               res
);
  localparam logic [2:0] S_IDLE = 3'd0, S_SCAN = 3'd1, S_DIV1 = 3'd2,
                         S_DIV2 = 3'd3, S_OUT = 3'd4;
  localparam int DB = SIZE_BITS + 16;  // dividend bits
  logic [2:0]           st_r;
  logic [PI_BITS-1:0]   k_r, m_r;
  logic [PC_BITS:0]     pop_r, bpop_r;
  logic [SIZE_BITS-1:0] best_r;
  logic [5:0]           it_r;
  logic [DB-1:0]        q_r;
  logic [SUM_BITS:0]    rem_r;
  logic [SUM_BITS-1:0]  den_r;
  result_t              res_r;
  logic                 last_m, last_k;
  logic [PC_BITS:0]     pop_n;
  logic [SUM_BITS+1:0]  tr;
  logic [Q_BITS-1:0]    qsat;

  // The front state is read live until the last division step, so the
  // window request is released only once nothing more is read from it.
  assign go_ready  = ((st_r == S_IDLE) && (pcount_i == '0)) ||
                     ((st_r == S_DIV2) && (it_r == 6'(DB)));
  assign res_valid = (st_r == S_OUT);
  assign res = res_r;
  assign last_m = ({1'b0, m_r} == pcount_i - 1'b1);
  assign last_k = ({1'b0, k_r} == pcount_i - 1'b1);
  assign pop_n = pop_r + (PC_BITS+1)'(plist_i[m_r] == plist_i[k_r]);
  assign tr = {rem_r, q_r[DB-1]};
  assign qsat = (q_r > DB'(32'h10000)) ? Q_BITS'(32'h10000) : q_r[Q_BITS-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
    end else begin
      unique case (st_r) inside
        S_IDLE: if (go_valid) begin
          res_r.largest_size <= 16'(max_i);
          res_r.total_size <= sum_i;
          res_r.count_short <= cnt_i[0];
          res_r.count_middle <= cnt_i[1];
          res_r.count_long <= cnt_i[2];
          res_r.pivot_found <= (pcount_i != '0);
          res_r.pivot_to_largest <= '0; res_r.pivot_to_total <= '0;
          k_r <= '0; m_r <= '0; pop_r <= '0; bpop_r <= '0; best_r <= '0;
          st_r <= (pcount_i != '0) ? S_SCAN : S_OUT;
          if (pcount_i == '0) res_r.mode_size <= '0;
        end
        S_SCAN: begin
          if (last_m) begin
            if (pop_n > bpop_r) begin bpop_r <= pop_n; best_r <= plist_i[k_r]; end
            pop_r <= '0; m_r <= '0; k_r <= k_r + 1'b1;
            if (last_k) begin
              res_r.mode_size <= 16'((pop_n > bpop_r) ? plist_i[k_r] : best_r);
              q_r <= {((pop_n > bpop_r) ? plist_i[k_r] : best_r), 16'h0};
              rem_r <= '0; den_r <= SUM_BITS'(max_i); it_r <= '0;
              st_r <= S_DIV1;
            end
          end else begin
            pop_r <= pop_n; m_r <= m_r + 1'b1;
          end
        end
        S_DIV1, S_DIV2: begin
          if (it_r == 6'(DB)) begin
            if (st_r == S_DIV1) begin
              res_r.pivot_to_largest <= (den_r == '0) ? '0 : qsat;
              q_r <= {best_r, 16'h0}; rem_r <= '0; den_r <= sum_i; it_r <= '0;
              st_r <= S_DIV2;
            end else begin
              res_r.pivot_to_total <= (den_r == '0) ? '0 : qsat;
              st_r <= S_OUT;
            end
          end else begin
            it_r <= it_r + 1'b1;
            if (tr >= {2'b0, den_r}) begin
              rem_r <= (SUM_BITS+1)'(tr - {2'b0, den_r});
              q_r <= {q_r[DB-2:0], 1'b1};
            end else begin
              rem_r <= tr[SUM_BITS:0];
              q_r <= {q_r[DB-2:0], 1'b0};
            end
          end
        end
        S_OUT: if (res_ready) st_r <= S_IDLE;
        default: st_r <= S_IDLE;
      endcase
    end
  end
endmodule

// File: rtl/packet_size_pivot_fingerprint.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// packet_size_pivot_fingerprint
// Channel | direction | contents
// in_     | slave     | tdata: frame_size[15:0]; tuser: starts_record
// out_    | master    | tdata: result fields, lowest first, 112 bits
// Frames pass through the two-entry queue into the window logic.
// The last window frame starts a pivot scan over every pair of pivots, then
// two divisions; when no pivot was found the result goes straight to the
// output state.
// Frames stall while the scan and divisions read the window state; a result
// held at the output stalls only the next finished window.
// Reset is synchronous and clears all control state; nothing else waits.
// ----------------------------------------------------------------------------
module packet_size_pivot_fingerprint import pspf_pkg::*; (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  input  logic [15:0]  in_tdata,   // frame_size
  input  logic         in_tuser,   // starts_record
  output logic         out_tvalid,
  input  logic         out_tready,
  // pivot_found, mode_size, largest_size, total_size, pivot_to_largest,
  // pivot_to_total, count_short, count_middle, count_long, zero fill
  output logic [111:0] out_tdata
);
  frame_req_t qin, qout;
  logic qv, qr, dv, dr;
  logic [SIZE_BITS-1:0] mx;
  logic [SUM_BITS-1:0] sm;
  logic [CNT_BITS-1:0] cn [3];
  logic [PC_BITS-1:0] pc;
  logic [SIZE_BITS-1:0] pl [MAX_PIVOTS];
  result_t rs;

  assign qin.size = in_tdata;
  assign qin.start = in_tuser;

  pspf_fifo u_fifo (.clk, .rst_n, .wr_valid(in_tvalid), .wr_ready(in_tready),
    .wr_data(qin), .rd_valid(qv), .rd_ready(qr), .rd_data(qout));
  pspf_front u_front (.clk, .rst_n, .req_valid(qv), .req_ready(qr), .req(qout),
    .done_valid(dv), .done_ready(dr), .max_o(mx), .sum_o(sm), .cnt_o(cn),
    .pcount_o(pc), .plist_o(pl));
  pspf_back u_back (.clk, .rst_n, .go_valid(dv), .go_ready(dr), .max_i(mx),
    .sum_i(sm), .cnt_i(cn), .pcount_i(pc), .plist_i(pl), .res_valid(out_tvalid),
    .res_ready(out_tready), .res(rs));

  assign out_tdata = {5'b0, rs.count_long, rs.count_middle, rs.count_short,
    rs.pivot_to_total, rs.pivot_to_largest, rs.total_size, rs.largest_size,
    rs.mode_size, rs.pivot_found};

  // The window logic holds its result until the back end has taken it.
  assert property (@(posedge clk) disable iff (!rst_n) dv && !dr |=> dv)
    else $error("window done dropped");
  // Ratios never exceed one.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> rs.pivot_to_largest <= 17'h10000 && rs.pivot_to_total <= 17'h10000)
    else $error("ratio overflow");
  // No pivot means the mode size and the pivot-to-total ratio are zero.
  assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !rs.pivot_found |-> rs.mode_size == 16'h0 && rs.pivot_to_total == '0)
    else $error("pivot fields set without pivot");
endmodule
